### rtl/ksa_pkg.sv
// Shared constants, codes, types and the arctangent table for the steering angle block.
`default_nettype none
package ksa_pkg;

  // CORDIC sequencing
  localparam int CORDIC_ITERATIONS = 16;
  localparam int ITER_W            = $clog2(CORDIC_ITERATIONS);
  localparam int ATAN_IDX_W        = 5;

  // datapath widths
  localparam int CW         = 36;   // CORDIC x / y
  localparam int ZW         = 19;   // CORDIC angle, Q16 radians
  localparam int YP_W       = 32;   // wheelbase * yaw product
  localparam int MUL_A_W    = ZW;
  localparam int MUL_B_W    = 16;
  localparam int DIGIT_W    = 4;
  localparam int MUL_DIGITS = MUL_B_W / DIGIT_W;
  localparam int MUL_CNT_W  = $clog2(MUL_DIGITS);
  localparam int MUL_HI_W   = MUL_A_W + DIGIT_W + 1;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int OUT_W      = 24;
  localparam int FRAC_SHIFT = 12;
  localparam int SPD_FRAC   = 12;

  // register reset values
  localparam logic [15:0] WHEELBASE_RST   = 16'd678;
  localparam logic [15:0] STEER_RATIO_RST = 16'd4429;
  localparam logic [14:0] MIN_SPEED_RST   = 15'd13;
  localparam logic [4:0]  TIMEOUT_RST     = 5'd12;
  localparam logic [4:0]  AGE_MAX         = 5'd31;

  typedef enum logic [1:0] {
    CMD_YAW   = 2'd0,
    CMD_SPEED = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    REG_WHEELBASE   = 2'd0,
    REG_STEER_RATIO = 2'd1,
    REG_MIN_SPEED   = 2'd2,
    REG_TIMEOUT     = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_Y,
    ST_CORDIC,
    ST_MUL_S,
    ST_ROUND,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic                       start;
    logic signed [MUL_A_W-1:0]  a;
    logic [MUL_B_W-1:0]         b;
  } mul_req_t;

  typedef struct packed {
    logic                       done;
    logic signed [PROD_W-1:0]   product;
  } mul_rsp_t;

  typedef struct packed {
    logic                       start;
    logic signed [CW-1:0]       x0;
    logic signed [CW-1:0]       y0;
  } cordic_req_t;

  typedef struct packed {
    logic                       done;
    logic signed [ZW-1:0]       angle;
  } cordic_rsp_t;

  // atan(2^-i) in Q16 radians, rounded to nearest
  function automatic logic [15:0] atan_q16(input logic [ATAN_IDX_W-1:0] i);
    logic [15:0] r;
    case (i)
      5'd0:    r = 16'd51472;
      5'd1:    r = 16'd30386;
      5'd2:    r = 16'd16055;
      5'd3:    r = 16'd8150;
      5'd4:    r = 16'd4091;
      5'd5:    r = 16'd2047;
      5'd6:    r = 16'd1024;
      5'd7:    r = 16'd512;
      5'd8:    r = 16'd256;
      5'd9:    r = 16'd128;
      5'd10:   r = 16'd64;
      5'd11:   r = 16'd32;
      5'd12:   r = 16'd16;
      5'd13:   r = 16'd8;
      5'd14:   r = 16'd4;
      5'd15:   r = 16'd2;
      5'd16:   r = 16'd1;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/ksa_mul.sv
// Radix-16 digit-serial signed by unsigned multiplier, one digit of b per cycle.
`default_nettype none
module ksa_mul
  import ksa_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire mul_req_t req,
  output mul_rsp_t      rsp
);

  logic                       busy;
  logic                       done;
  logic [MUL_CNT_W-1:0]       cnt;
  logic signed [MUL_A_W-1:0]  a_reg;
  logic signed [MUL_HI_W-1:0] hi;
  logic [MUL_B_W-1:0]         lo;
  logic signed [MUL_HI_W-1:0] sum;
  logic [DIGIT_W-1:0]         digit;

  // add one partial product, then shift the pair right by a digit
  assign digit = lo[DIGIT_W-1:0];
  assign sum   = hi + a_reg * $signed({1'b0, digit});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == MUL_CNT_W'(MUL_DIGITS - 1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == MUL_CNT_W'(MUL_DIGITS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // operand and product registers
  always_ff @(posedge clk) begin
    if (req.start) begin
      a_reg <= req.a;
      hi    <= '0;
      lo    <= req.b;
    end else if (busy) begin
      hi <= {{DIGIT_W{sum[MUL_HI_W-1]}}, sum[MUL_HI_W-1:DIGIT_W]};
      lo <= {sum[DIGIT_W-1:0], lo[MUL_B_W-1:DIGIT_W]};
    end
  end

  // upper part of the product sits in hi, lower part in lo
  assign rsp.done    = done;
  assign rsp.product = $signed({hi[PROD_W-MUL_B_W-1:0], lo});

endmodule
`default_nettype wire

### rtl/ksa_cordic.sv
// Iterative vectoring CORDIC: one rotation per cycle, angle in Q16 radians.
`default_nettype none
module ksa_cordic
  import ksa_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cordic_req_t req,
  output cordic_rsp_t      rsp
);

  logic                 busy;
  logic                 done;
  logic [ITER_W-1:0]    cnt;
  logic signed [CW-1:0] x;
  logic signed [CW-1:0] y;
  logic signed [ZW-1:0] z;
  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic signed [ZW-1:0] ang;

  // floor shifts and table angle for this step
  assign xs  = x >>> cnt;
  assign ys  = y >>> cnt;
  assign ang = ZW'($signed({1'b0, atan_q16(ATAN_IDX_W'(cnt))}));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == ITER_W'(CORDIC_ITERATIONS - 1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == ITER_W'(CORDIC_ITERATIONS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // rotate toward the x axis
  always_ff @(posedge clk) begin
    if (req.start) begin
      x <= req.x0;
      y <= req.y0;
      z <= '0;
    end else if (busy) begin
      if (!y[CW-1]) begin
        x <= x + ys;
        y <= y - xs;
        z <= z + ang;
      end else begin
        x <= x - ys;
        y <= y + xs;
        z <= z - ang;
      end
    end
  end

  assign rsp.done  = done;
  assign rsp.angle = z;

endmodule
`default_nettype wire

### rtl/kinematic_steering_angle.sv
// Top level: command/speed holding, tick sequencing and steering output register.
//
// Input channel (in_valid / in_stall) carries one request: cmd, yaw_rate, speed.
//   cmd 0 stores yaw_rate as the new command and clears its age, cmd 1 stores
//   speed, cmd 2 is a control tick, cmd 3 is ignored.
// A tick ages the command; if a command exists and is no older than
//   timeout_ticks it produces one steer_cmd on the output channel
//   (out_valid / out_stall), otherwise nothing.
// A tick steps through a radix-16 multiply for wheelbase * yaw, one CORDIC
//   rotation per cycle, a second multiply by steer_ratio, one rounding state
//   and the output load. A tick with |speed| below min_speed gives 0 without
//   the multiply and CORDIC steps.
// in_stall is high while a tick is being computed, so one tick is worked on
//   at a time; update requests are taken while a result waits on the output.
// If the receiver stalls, the result holds in the output register and a new
//   result waits in the sequencer until the register frees.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 wheelbase,
//   1 steer_ratio, 2 min_speed, 3 timeout_ticks); write only while idle.
// Reset (rst, synchronous) restores register defaults, clears held values,
//   command age and valid flags.
`default_nettype none
module kinematic_steering_angle
  import ksa_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         cmd,
  input  wire logic signed [15:0] yaw_rate,
  input  wire logic signed [15:0] speed,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [23:0]      steer_cmd
);

  state_t state, state_next;

  logic [15:0]        wheelbase;
  logic [15:0]        steer_ratio;
  logic [14:0]        min_speed;
  logic [4:0]         timeout_ticks;
  logic signed [15:0] held_yaw_rate;
  logic signed [15:0] held_speed;
  logic [4:0]         command_age;
  logic               command_seen;
  logic [OUT_W-1:0]   res;
  logic [OUT_W-1:0]   res_next;
  logic               res_load;
  logic               out_load;
  logic               in_accept;

  mul_req_t    mul_req;
  mul_rsp_t    mul_rsp;
  cordic_req_t cordic_req;
  cordic_rsp_t cordic_rsp;

  logic [4:0]           age_inc;
  logic                 tick_ok;
  logic                 spd_neg;
  logic [15:0]          spd_abs;
  logic                 slow;
  logic signed [CW-1:0] y_ext;
  logic signed [CW-1:0] y0;
  logic signed [CW-1:0] x0;
  logic [PROD_W:0]      p_ext;
  logic                 p_neg;
  logic [PROD_W:0]      mag;
  logic [PROD_W:0]      rsum;
  logic [OUT_W-1:0]     rnd;
  logic [OUT_W-1:0]     rounded;

  ksa_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  ksa_cordic u_cordic (
    .clk (clk),
    .rst (rst),
    .req (cordic_req),
    .rsp (cordic_rsp)
  );

  assign in_accept = in_valid && !in_stall;

  // tick qualification
  assign age_inc = (command_age != AGE_MAX) ? command_age + 5'd1 : command_age;
  assign tick_ok = command_seen && (age_inc <= timeout_ticks);
  assign spd_neg = held_speed[15];
  assign spd_abs = spd_neg ? 16'(-held_speed) : held_speed;
  assign slow    = spd_abs < {1'b0, min_speed};

  // CORDIC operands: y is negated and x is built from |speed| when speed is negative
  assign y_ext = CW'($signed(mul_rsp.product[YP_W-1:0]));
  assign y0    = spd_neg ? -y_ext : y_ext;
  assign x0    = CW'({spd_abs, {SPD_FRAC{1'b0}}});

  // round magnitude half away from zero, then saturate
  assign p_ext   = {mul_rsp.product[PROD_W-1], mul_rsp.product};
  assign p_neg   = mul_rsp.product[PROD_W-1];
  assign mag     = p_neg ? -p_ext : p_ext;
  assign rsum    = mag + (PROD_W + 1)'(1 << (FRAC_SHIFT - 1));
  assign rnd     = rsum[PROD_W:FRAC_SHIFT];
  assign rounded = p_neg ? (rnd[OUT_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : -rnd)
                         : (rnd[OUT_W-1] ? {1'b0, {(OUT_W-1){1'b1}}} : rnd);

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer next state and unit requests
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    mul_req    = '0;
    cordic_req = '0;
    res_next   = '0;
    res_load   = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && cmd == CMD_TICK && tick_ok) begin
          if (slow) begin
            res_load   = 1'b1;
            state_next = ST_FIN;
          end else begin
            mul_req.start = 1'b1;
            mul_req.a     = MUL_A_W'(held_yaw_rate);
            mul_req.b     = wheelbase;
            state_next    = ST_MUL_Y;
          end
        end
      end
      ST_MUL_Y: begin
        if (mul_rsp.done) begin
          cordic_req.start = 1'b1;
          cordic_req.x0    = x0;
          cordic_req.y0    = y0;
          state_next       = ST_CORDIC;
        end
      end
      ST_CORDIC: begin
        if (cordic_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = cordic_rsp.angle;
          mul_req.b     = steer_ratio;
          state_next    = ST_MUL_S;
        end
      end
      ST_MUL_S: begin
        if (mul_rsp.done) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        res_next   = rounded;
        res_load   = 1'b1;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wheelbase     <= WHEELBASE_RST;
      steer_ratio   <= STEER_RATIO_RST;
      min_speed     <= MIN_SPEED_RST;
      timeout_ticks <= TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WHEELBASE:   wheelbase     <= cfg_data;
        REG_STEER_RATIO: steer_ratio   <= cfg_data;
        REG_MIN_SPEED:   min_speed     <= cfg_data[14:0];
        REG_TIMEOUT:     timeout_ticks <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // held command, speed and command age
  always_ff @(posedge clk) begin
    if (rst) begin
      held_yaw_rate <= '0;
      held_speed    <= '0;
      command_age   <= '0;
      command_seen  <= 1'b0;
    end else if (in_accept) begin
      if (cmd == CMD_YAW) begin
        held_yaw_rate <= yaw_rate;
        command_age   <= '0;
        command_seen  <= 1'b1;
      end else if (cmd == CMD_SPEED) begin
        held_speed <= speed;
      end else if (cmd == CMD_TICK) begin
        command_age <= age_inc;
      end
    end
  end

  // result holding register
  always_ff @(posedge clk) begin
    if (res_load) begin
      res <= res_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      steer_cmd <= res;
    end
  end

  // multiplier finishes only while the sequencer waits on it
  a_mul_done_state: assert property (@(posedge clk) disable iff (rst)
    mul_rsp.done |-> (state == ST_MUL_Y || state == ST_MUL_S))
    else $error("multiplier done outside a multiply state");

  // CORDIC finishes only while the sequencer waits on it
  a_cordic_done_state: assert property (@(posedge clk) disable iff (rst)
    cordic_rsp.done |-> state == ST_CORDIC)
    else $error("CORDIC done outside the CORDIC state");

  // a new command resets its age
  a_cmd_fresh: assert property (@(posedge clk) disable iff (rst)
    (in_accept && cmd == CMD_YAW) |=> (command_age == '0 && command_seen))
    else $error("yaw command did not reset age");

  // a finished result is handed to a free output register
  a_fin_load: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && !(out_valid && out_stall)) |=> (out_valid && state == ST_IDLE))
    else $error("finished result not loaded into output register");

endmodule
`default_nettype wire

### tb/kinematic_steering_angle_test.sv
// Self-checking testbench for the kinematic steering angle block.
`timescale 1ns / 100ps

module kinematic_steering_angle_test;
  import ksa_pkg::*;

  localparam logic [1:0] CMD_UNUSED    = 2'd3;
  localparam int         SETTLE_CYCLES = 40;
  localparam int         IDLE_LIMIT    = 2000;
  localparam int         MAX_PRINTS    = 100;
  localparam longint     STEER_MAX     = 8388607;
  localparam longint     STEER_MIN     = -8388608;

  // atan(2^-i) in Q16 radians
  localparam longint ATAN_Q16_TBL [0:23] = '{
    51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2,
    1, 0, 0, 0, 0, 0, 0, 0
  };

  typedef struct {
    logic [1:0]         op;
    logic signed [15:0] yaw;
    logic signed [15:0] spd;
  } steer_req_t;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               cfg_we    = 1'b0;
  logic [1:0]         cfg_index = REG_WHEELBASE;
  logic [15:0]        cfg_data  = '0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic [1:0]         cmd       = CMD_YAW;
  logic signed [15:0] yaw_rate  = '0;
  logic signed [15:0] speed     = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [23:0] steer_cmd;

  kinematic_steering_angle dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .yaw_rate  (yaw_rate),
    .speed     (speed),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .steer_cmd (steer_cmd)
  );

  always #1 clk = ~clk;

  // predictor copy of registers and held state
  logic [15:0]        wheelbase_q;
  logic [15:0]        ratio_q;
  logic [14:0]        min_speed_q;
  logic [4:0]         timeout_q;
  logic signed [15:0] held_yaw;
  logic signed [15:0] held_spd;
  logic [4:0]         cmd_age;
  logic               cmd_seen;

  steer_req_t         pending[$];
  steer_req_t         cur_req;
  logic signed [23:0] steer_expected[$];
  int                 issued_cnt   = 0;
  int                 accepted_cnt = 0;
  int                 mismatches   = 0;
  int                 src_wait     = 0;
  int                 sink_wait    = 0;
  int                 idle_cycles  = 0;
  bit                 src_idle     = 1'b1;
  bit                 sink_idle    = 1'b1;

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTS)
      $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // bicycle model: ratio * atan(wheelbase * yaw / speed) through CORDIC vectoring
  function automatic logic signed [23:0] bicycle_steer();
    longint y, x, z, s, xs, ys, prod, mag;
    bit     neg;
    int     i;
    y = longint'(wheelbase_q) * longint'(held_yaw);
    s = longint'(held_spd);
    if (s < 0) begin
      s = -s;
      y = -y;
    end
    if (s < longint'(min_speed_q))
      return '0;
    x = s * 4096;
    z = 0;
    for (i = 0; i < CORDIC_ITERATIONS && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_Q16_TBL[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_Q16_TBL[i];
      end
    end
    prod = z * longint'(ratio_q);
    neg  = prod < 0;
    mag  = neg ? -prod : prod;
    mag  = (mag + 2048) >>> 12;
    if (neg)
      mag = -mag;
    if (mag > STEER_MAX)
      mag = STEER_MAX;
    if (mag < STEER_MIN)
      mag = STEER_MIN;
    return mag[23:0];
  endfunction

  // state update for one accepted request
  task automatic apply_request(input steer_req_t r);
    case (r.op)
      CMD_YAW: begin
        held_yaw = r.yaw;
        cmd_age  = '0;
        cmd_seen = 1'b1;
      end
      CMD_SPEED: begin
        held_spd = r.spd;
      end
      CMD_TICK: begin
        if (cmd_age < AGE_MAX)
          cmd_age = cmd_age + 5'd1;
        if (cmd_seen && cmd_age <= timeout_q)
          steer_expected.push_back(bicycle_steer());
      end
      default: begin
      end
    endcase
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 85)
      return $urandom_range(1, 3);
    if (r < 97)
      return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [15:0] rand_yaw();
    int v;
    case ($urandom_range(0, 3))
      0, 1: v = $urandom_range(0, 65535) - 32768;
      2:    v = $urandom_range(0, 1024) - 512;
      default: v = $urandom_range(0, 1) ? 32767 : -32768;
    endcase
    return v[15:0];
  endfunction

  // speeds cluster around the min_speed threshold as well as the full range
  function automatic logic signed [15:0] rand_speed();
    int v;
    case ($urandom_range(0, 3))
      0: v = $urandom_range(0, 65535) - 32768;
      1: begin
        v = int'(min_speed_q) + $urandom_range(0, 4) - 2;
        if (v > 32767)
          v = 32767;
        if (v < 0)
          v = 0;
        if ($urandom_range(0, 1))
          v = -v;
      end
      2: v = $urandom_range(0, 512) - 256;
      default: v = $urandom_range(0, 1) ? 32767 : -32768;
    endcase
    return v[15:0];
  endfunction

  task automatic add_req(input logic [1:0] op, input logic signed [15:0] yaw,
                         input logic signed [15:0] spd);
    steer_req_t r;
    r.op  = op;
    r.yaw = yaw;
    r.spd = spd;
    pending.push_back(r);
    issued_cnt++;
  endtask

  task automatic add_yaw(input logic signed [15:0] yaw);
    add_req(CMD_YAW, yaw, 16'($urandom));
  endtask

  task automatic add_speed(input logic signed [15:0] spd);
    add_req(CMD_SPEED, 16'($urandom), spd);
  endtask

  task automatic add_ticks(input int n);
    repeat (n) add_req(CMD_TICK, 16'($urandom), 16'($urandom));
  endtask

  // bursts of speed/yaw updates followed by ticks, plus some noise
  task automatic add_random(input int n);
    int cnt;
    int k;
    logic [1:0] op;
    cnt = 0;
    while (cnt < n) begin
      if ($urandom_range(0, 99) < 8) begin
        op = 2'($urandom_range(0, 3));
        add_req(op, 16'($urandom), 16'($urandom));
        if (op != CMD_UNUSED)
          cnt++;
      end else begin
        if ($urandom_range(0, 1)) begin
          add_speed(rand_speed());
          cnt++;
        end
        if ($urandom_range(0, 99) < 85) begin
          add_yaw(rand_yaw());
          cnt++;
        end
        k = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 35) : $urandom_range(1, 6);
        add_ticks(k);
        cnt += k;
      end
    end
  endtask

  // register writes; unused upper data bits carry junk
  task automatic set_vehicle(input logic [15:0] wb, input logic [15:0] ratio,
                             input logic [14:0] msp, input logic [4:0] tmo);
    wheelbase_q = wb;
    ratio_q     = ratio;
    min_speed_q = msp;
    timeout_q   = tmo;
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_WHEELBASE;
    cfg_data  <= wb;
    @(posedge clk);
    cfg_index <= REG_STEER_RATIO;
    cfg_data  <= ratio;
    @(posedge clk);
    cfg_index <= REG_MIN_SPEED;
    cfg_data  <= {1'($urandom), msp};
    @(posedge clk);
    cfg_index <= REG_TIMEOUT;
    cfg_data  <= {11'($urandom), tmo};
    @(posedge clk);
    cfg_we    <= 1'b0;
    src_idle  = $urandom_range(0, 3) != 0;
    sink_idle = $urandom_range(0, 3) != 0;
  endtask

  // wait for every request taken and every result drained, then let the block go quiet
  task automatic settle();
    while (accepted_cnt != issued_cnt || steer_expected.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      src_wait = 0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_request(cur_req);
        accepted_cnt++;
      end
      if (!in_valid || !in_stall) begin
        if (src_wait > 0) begin
          src_wait--;
          in_valid <= 1'b0;
        end else if (pending.size() != 0) begin
          cur_req = pending.pop_front();
          in_valid <= 1'b1;
          cmd      <= cur_req.op;
          yaw_rate <= cur_req.yaw;
          speed    <= cur_req.spd;
          src_wait = src_idle ? pick_gap() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    logic signed [23:0] want;
    if (rst) begin
      out_stall <= 1'b0;
      sink_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (steer_expected.size() == 0) begin
          report_mismatch($sformatf("unexpected steer_cmd %0d", steer_cmd));
        end else begin
          want = steer_expected.pop_front();
          if (steer_cmd !== want)
            report_mismatch($sformatf("steer_cmd %0d, expected %0d", steer_cmd, want));
        end
      end
      if (sink_wait > 0) begin
        sink_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        sink_wait = sink_idle ? pick_gap() : 0;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wheelbase_q = WHEELBASE_RST;
    ratio_q     = STEER_RATIO_RST;
    min_speed_q = MIN_SPEED_RST;
    timeout_q   = TIMEOUT_RST;
    held_yaw    = '0;
    held_spd    = '0;
    cmd_age     = '0;
    cmd_seen    = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset defaults: no command yet, ignored selector, slow and extreme speeds
    add_ticks(1);
    add_req(CMD_UNUSED, 16'($urandom), 16'($urandom));
    add_speed(16'sd0);
    add_yaw(16'sd4096);
    add_ticks(1);
    add_speed(16'sd12);
    add_ticks(1);
    add_speed(16'sd13);
    add_ticks(1);
    add_speed(-16'sd13);
    add_ticks(1);
    add_speed(16'sd32767);
    add_yaw(16'sd32767);
    add_ticks(1);
    add_yaw(-16'sd32768);
    add_ticks(1);
    add_speed(-16'sd32768);
    add_ticks(1);
    add_yaw(16'sd0);
    add_ticks(1);
    add_speed(-16'sd1);
    add_ticks(1);
    add_random(75);
    settle();

    // zero wheelbase, full ratio, timeout of one: second tick is stale
    set_vehicle(16'd0, 16'hFFFF, 15'd0, 5'd1);
    add_yaw(16'sd100);
    add_ticks(3);
    add_random(75);
    settle();

    // zero ratio, highest min_speed, longest timeout
    set_vehicle(16'hFFFF, 16'd0, 15'h7FFF, 5'd31);
    add_yaw(rand_yaw());
    add_speed(16'sd32767);
    add_ticks(1);
    add_speed(-16'sd32768);
    add_ticks(1);
    add_speed(16'sd32766);
    add_ticks(1);
    add_random(70);
    settle();

    // zero speed with no minimum, then age saturation
    set_vehicle(16'hFFFF, 16'hFFFF, 15'd0, 5'd31);
    add_speed(16'sd0);
    add_yaw(16'sd32767);
    add_ticks(1);
    add_yaw(-16'sd32768);
    add_ticks(1);
    add_yaw(16'sd0);
    add_ticks(1);
    add_yaw(16'sd1);
    add_ticks(34);
    add_random(75);
    settle();

    // timeout of zero never allows output
    set_vehicle(WHEELBASE_RST, STEER_RATIO_RST, MIN_SPEED_RST, 5'd0);
    add_yaw(16'sd2000);
    add_ticks(2);
    add_random(30);
    settle();

    // random vehicles
    set_vehicle(16'($urandom), 16'($urandom), 15'($urandom_range(0, 600)),
                5'($urandom_range(1, 31)));
    add_random(70);
    settle();

    set_vehicle(16'($urandom), 16'($urandom), 15'($urandom), 5'($urandom_range(1, 31)));
    add_random(70);
    settle();

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
